/* rtl/core/edi_pkg.sv */
package edi_pkg;

  // Default coordinate width and the fixed result widths.
  localparam int unsigned COORD_BITS_DEF = 30;
  localparam int unsigned DIST2_W        = 61;
  localparam int unsigned DIST_W         = 31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SUM,
    ST_ROOT,
    ST_WB
  } state_e;

endpackage

/* rtl/core/edi_if.sv */
interface edi_in_if #(
  parameter int unsigned CoordBits = edi_pkg::COORD_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [CoordBits-1:0] point_a_x;
  logic signed [CoordBits-1:0] point_a_y;
  logic signed [CoordBits-1:0] point_b_x;
  logic signed [CoordBits-1:0] point_b_y;

  modport source (
    output valid, point_a_x, point_a_y, point_b_x, point_b_y,
    input  ready
  );
  modport sink (
    input  valid, point_a_x, point_a_y, point_b_x, point_b_y,
    output ready
  );
endinterface

interface edi_out_if;
  logic                          valid;
  logic                          ready;
  logic [edi_pkg::DIST2_W-1:0]   distance_squared;
  logic [edi_pkg::DIST_W-1:0]    distance;

  modport source (
    output valid, distance_squared, distance,
    input  ready
  );
  modport sink (
    input  valid, distance_squared, distance,
    output ready
  );
endinterface

/* rtl/core/euclidean_distance_isqrt_top.sv */
// One item at a time: an accepted item runs through SQ_X, SQ_Y, SUM, ROOT and WB, and
// the next is taken once WB, free to load, fills the output register; the restoring root settles one
// bit per cycle in a shared compare/subtract unit, after two passes through one
// shared squaring multiplier. The output register holds a result while the next
// item is taken. Reset (rst_ni low, asynchronous) empties the block; no state kept.
module euclidean_distance_isqrt_top #(
  parameter int unsigned COORD_BITS = edi_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  edi_in_if.sink      in_i,
  edi_out_if.source   out_o
);

  localparam int unsigned SqW   = 2 * COORD_BITS;
  localparam int unsigned D2W   = 2 * COORD_BITS + 1;
  localparam int unsigned RootW = COORD_BITS + 1;
  localparam int unsigned OutW2 = edi_pkg::DIST2_W;
  localparam int unsigned OutW  = edi_pkg::DIST_W;

  edi_pkg::state_e state_q, state_d;

  logic [COORD_BITS-1:0] mag_x_q, mag_y_q;
  logic [SqW-1:0]        sq_q;
  logic [D2W-1:0]        rem_q, root_q, bit_q, d2_q;
  logic [D2W-1:0]        dist2_q;
  logic [RootW-1:0]      dist_q;
  logic                  out_valid_q;

  // Sequencer outputs
  logic in_ready, ld_mag, ld_sq_x, ld_sq_y, ld_sum, step_root, ld_out;
  logic out_free;

  // Magnitudes of the coordinate differences
  logic signed [COORD_BITS:0] diff_x, diff_y;
  logic        [COORD_BITS:0] neg_x, neg_y;
  logic [COORD_BITS-1:0]      abs_x, abs_y;

  // Shared squaring multiplier
  logic [COORD_BITS-1:0] mul_op;
  logic [SqW-1:0]        mul_p;

  // Shared compare/subtract of the root
  logic [D2W-1:0] trial, rem_sub;
  logic           take;

  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    diff_x = (COORD_BITS+1)'(in_i.point_a_x) - (COORD_BITS+1)'(in_i.point_b_x);
    diff_y = (COORD_BITS+1)'(in_i.point_a_y) - (COORD_BITS+1)'(in_i.point_b_y);
    neg_x  = -diff_x;
    neg_y  = -diff_y;
    abs_x  = diff_x[COORD_BITS] ? neg_x[COORD_BITS-1:0] : diff_x[COORD_BITS-1:0];
    abs_y  = diff_y[COORD_BITS] ? neg_y[COORD_BITS-1:0] : diff_y[COORD_BITS-1:0];
  end

  always_comb begin
    mul_op = (state_q == edi_pkg::ST_SQ_X) ? mag_x_q : mag_y_q;
    mul_p  = SqW'(mul_op) * SqW'(mul_op);
  end

  always_comb begin
    trial   = root_q | bit_q;
    take    = rem_q >= trial;
    rem_sub = rem_q - trial;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      edi_pkg::ST_IDLE: begin
        if (in_i.valid) state_d = edi_pkg::ST_SQ_X;
      end
      edi_pkg::ST_SQ_X: state_d = edi_pkg::ST_SQ_Y;
      edi_pkg::ST_SQ_Y: state_d = edi_pkg::ST_SUM;
      edi_pkg::ST_SUM:  state_d = edi_pkg::ST_ROOT;
      edi_pkg::ST_ROOT: begin
        if (bit_q[0]) state_d = edi_pkg::ST_WB;
      end
      edi_pkg::ST_WB: begin
        if (out_free) state_d = edi_pkg::ST_IDLE;
      end
      default: state_d = edi_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    ld_mag    = 1'b0;
    ld_sq_x   = 1'b0;
    ld_sq_y   = 1'b0;
    ld_sum    = 1'b0;
    step_root = 1'b0;
    ld_out    = 1'b0;
    case (state_q)
      edi_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        ld_mag   = in_i.valid;
      end
      edi_pkg::ST_SQ_X: ld_sq_x   = 1'b1;
      edi_pkg::ST_SQ_Y: ld_sq_y   = 1'b1;
      edi_pkg::ST_SUM:  ld_sum    = 1'b1;
      edi_pkg::ST_ROOT: step_root = 1'b1;
      edi_pkg::ST_WB:   ld_out    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= edi_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_mag) begin
      mag_x_q <= abs_x;
      mag_y_q <= abs_y;
    end
    if (ld_sq_x || ld_sq_y) begin
      sq_q <= mul_p;
    end
    if (ld_sq_y) begin
      rem_q <= D2W'(sq_q);
    end
    if (ld_sum) begin
      // Start at the top even bit: leading steps on a small value leave it untouched.
      rem_q  <= rem_q + D2W'(sq_q);
      d2_q   <= rem_q + D2W'(sq_q);
      root_q <= '0;
      bit_q  <= D2W'(1) << (D2W - 1);
    end
    if (step_root) begin
      if (take) begin
        rem_q  <= rem_sub;
        root_q <= (root_q >> 1) | bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (ld_out) begin
      dist2_q <= d2_q;
      dist_q  <= root_q[RootW-1:0];
    end
  end

  assign in_i.ready             = in_ready;
  assign out_o.valid            = out_valid_q;
  assign out_o.distance_squared = OutW2'(dist2_q);
  assign out_o.distance         = OutW'(dist_q);

  // The trial bit walks down as a single set bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == edi_pkg::ST_ROOT) |-> $onehot(bit_q))
    else $error("root trial bit is not one-hot");

  // A fresh result is the floor root of its squared distance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_out |=> (64'(out_o.distance) * 64'(out_o.distance)
                <= 64'(out_o.distance_squared)) &&
               ((64'(out_o.distance) + 64'd1) * (64'(out_o.distance) + 64'd1)
                > 64'(out_o.distance_squared)))
    else $error("distance is not the floor root of distance_squared");

  // No new item is taken while one is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_i.ready)
    else $error("input taken while an item is in flight");

endmodule

/* tb/tb_euclidean_distance_isqrt_top.sv */
`timescale 1ns / 100ps

module tb_euclidean_distance_isqrt_top;

  localparam int unsigned COORD_W     = edi_pkg::COORD_BITS_DEF;
  localparam int unsigned PIPE_LAT    = COORD_W + 6;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned HOLD_AFTER  = 100;
  localparam int unsigned HOLD_CYCLES = 600;

  localparam logic signed [COORD_W-1:0] C_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] C_ZERO = '0;
  localparam logic signed [COORD_W-1:0] C_NEG1 = '1;

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
  } point_pair_t;

  typedef struct packed {
    logic [edi_pkg::DIST2_W-1:0] dist2;
    logic [edi_pkg::DIST_W-1:0]  dist_root;
  } distance_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SHUT
  } rx_mode_e;

  logic clk_i;
  logic rst_ni;

  edi_in_if #(.CoordBits(COORD_W)) pts_if ();
  edi_out_if                       dist_if ();

  euclidean_distance_isqrt_top #(
    .COORD_BITS(COORD_W)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (pts_if.sink),
    .out_o (dist_if.source)
  );

  point_pair_t pending_pairs_q[$];
  distance_t   expected_dist_q[$];
  int unsigned fail_cnt;
  int unsigned cycle_cnt;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Squared distance and its floor root, one root bit per trial.
  function automatic distance_t predict_distance(input point_pair_t p);
    longint dx;
    longint dy;
    longint unsigned sum;
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    distance_t res;
    dx = longint'(p.ax) - longint'(p.bx);
    dy = longint'(p.ay) - longint'(p.by);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    sum = longint'(unsigned'(dx)) * longint'(unsigned'(dx))
        + longint'(unsigned'(dy)) * longint'(unsigned'(dy));
    rem = sum;
    root = 0;
    trial = 64'h4000_0000_0000_0000;
    while (trial > rem) trial = trial >> 2;
    while (trial != 0) begin
      if (rem >= root + trial) begin
        rem = rem - (root + trial);
        root = (root >> 1) + trial;
      end else begin
        root = root >> 1;
      end
      trial = trial >> 2;
    end
    res.dist2     = sum[edi_pkg::DIST2_W-1:0];
    res.dist_root = root[edi_pkg::DIST_W-1:0];
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] any_coord();
    return COORD_W'($urandom());
  endfunction

  function automatic logic signed [COORD_W-1:0] edge_coord();
    case ($urandom_range(0, 4))
      0: return C_MAX;
      1: return C_MIN;
      2: return C_ZERO;
      3: return C_NEG1;
      default: return any_coord();
    endcase
  endfunction

  task automatic add_pair(input logic signed [COORD_W-1:0] ax, ay, bx, by);
    point_pair_t p;
    p = '{ax: ax, ay: ay, bx: bx, by: by};
    pending_pairs_q.push_back(p);
  endtask

  task automatic add_random_pair();
    logic signed [COORD_W-1:0] ax, ay, bx, by;
    logic signed [COORD_W-1:0] k;
    ax = any_coord();
    ay = any_coord();
    bx = any_coord();
    by = any_coord();
    case ($urandom_range(0, 9))
      4, 5: begin
        // close points: small deltas, wrapping at the range ends is legal
        bx = ax + COORD_W'($signed($urandom_range(0, 32)) - 16);
        by = ay + COORD_W'($signed($urandom_range(0, 32)) - 16);
      end
      6: by = ay;
      7: begin
        // scaled 3-4-5 triangle gives an exact root unless a coordinate wraps at the range ends
        k = COORD_W'($urandom_range(1, 1 << 26));
        if ($urandom_range(0, 1)) k = -k;
        bx = ax + COORD_W'(3 * k);
        by = ay + COORD_W'(4 * k);
        if ($urandom_range(0, 1)) begin
          ax = C_ZERO;
          ay = C_ZERO;
          bx = COORD_W'(3 * k);
          by = COORD_W'(4 * k);
        end
      end
      8: begin
        ax = edge_coord();
        ay = edge_coord();
        bx = edge_coord();
        by = edge_coord();
      end
      9: begin
        bx = ax;
        by = ay;
      end
      default: ;
    endcase
    add_pair(ax, ay, bx, by);
  endtask

  // Driver: bursts of items from the pending queue with random gaps.
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i) begin : feed_points
    point_pair_t nxt;
    logic        offer;
    if (!rst_ni) begin
      pts_if.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      offer = pts_if.valid;
      nxt = '{ax: pts_if.point_a_x, ay: pts_if.point_a_y,
              bx: pts_if.point_b_x, by: pts_if.point_b_y};
      if (pts_if.valid && pts_if.ready) begin
        expected_dist_q.push_back(predict_distance(nxt));
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_pairs_q.size() != 0) begin
          nxt = pending_pairs_q.pop_front();
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
          end else begin
            burst_left--;
          end
        end
      end
      pts_if.valid     <= offer;
      pts_if.point_a_x <= nxt.ax;
      pts_if.point_a_y <= nxt.ay;
      pts_if.point_b_x <= nxt.bx;
      pts_if.point_b_y <= nxt.by;
    end
  end

  // Receiver pacing: random stretches open, choppy or shut, plus one long hold.
  rx_mode_e    rx_mode;
  int unsigned mode_left;
  int unsigned taken_cnt;
  int unsigned hold_left;
  logic        hold_done;

  always @(posedge clk_i) begin : pace_results
    logic ready_nxt;
    if (!rst_ni) begin
      dist_if.ready <= 1'b0;
      rx_mode = RX_OPEN;
      mode_left = 0;
      taken_cnt = 0;
      hold_left = 0;
      hold_done = 1'b0;
    end else begin
      if (dist_if.valid && dist_if.ready) taken_cnt++;
      if (hold_left != 0) begin
        hold_left--;
        ready_nxt = 1'b0;
      end else if (!hold_done && taken_cnt >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
        ready_nxt = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(1, 120);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_OPEN:   ready_nxt = 1'b1;
          RX_CHOPPY: ready_nxt = ($urandom_range(0, 2) != 0);
          default:   ready_nxt = 1'b0;
        endcase
      end
      dist_if.ready <= ready_nxt;
    end
  end

  // Monitor: compare every taken result with the oldest prediction.
  always @(posedge clk_i) begin : check_distance
    distance_t want;
    if (rst_ni && dist_if.valid && dist_if.ready) begin
      if (expected_dist_q.size() == 0) begin
        $display("%0t unexpected result: distance_squared %0d distance %0d",
                 $time, dist_if.distance_squared, dist_if.distance);
        fail_cnt++;
      end else begin
        want = expected_dist_q.pop_front();
        if (dist_if.distance_squared !== want.dist2) begin
          $display("%0t distance_squared mismatch: expected %0d, got %0d",
                   $time, want.dist2, dist_if.distance_squared);
          fail_cnt++;
        end
        if (dist_if.distance !== want.dist_root) begin
          $display("%0t distance mismatch: expected %0d, got %0d",
                   $time, want.dist_root, dist_if.distance);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, expected_dist_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    rst_ni = 1'b0;
    fail_cnt = 0;
    cycle_cnt = 0;
    pts_if.valid = 1'b0;
    pts_if.point_a_x = '0;
    pts_if.point_a_y = '0;
    pts_if.point_b_x = '0;
    pts_if.point_b_y = '0;
    dist_if.ready = 1'b0;

    // zero distance, equal points at the range ends
    add_pair(C_ZERO, C_ZERO, C_ZERO, C_ZERO);
    add_pair(C_MAX, C_MAX, C_MAX, C_MAX);
    add_pair(C_MIN, C_MIN, C_MIN, C_MIN);
    add_pair(C_MIN, C_MAX, C_MIN, C_MAX);
    // largest sums
    add_pair(C_MAX, C_MAX, C_MIN, C_MIN);
    add_pair(C_MIN, C_MIN, C_MAX, C_MAX);
    add_pair(C_MAX, C_MIN, C_MIN, C_MAX);
    add_pair(C_MAX, C_ZERO, C_MIN, C_ZERO);
    add_pair(C_ZERO, C_MIN, C_ZERO, C_MAX);
    add_pair(C_MIN, C_ZERO, C_ZERO, C_ZERO);
    add_pair(C_MAX, C_ZERO, C_ZERO, C_MAX);
    // small values around perfect squares
    add_pair(30'sd1, C_ZERO, C_ZERO, C_ZERO);
    add_pair(30'sd1, 30'sd1, C_ZERO, C_ZERO);
    add_pair(C_ZERO, C_ZERO, C_NEG1, C_NEG1);
    add_pair(30'sd2, C_ZERO, C_ZERO, C_ZERO);
    add_pair(30'sd2, 30'sd2, C_ZERO, C_ZERO);
    add_pair(30'sd3, C_ZERO, C_ZERO, C_ZERO);
    add_pair(30'sd3, 30'sd4, C_ZERO, C_ZERO);
    add_pair(C_ZERO, C_ZERO, 30'sd5, -30'sd5);
    add_pair(30'sd46341, C_ZERO, C_ZERO, 30'sd1);
    add_pair(C_NEG1, C_NEG1, C_NEG1, C_NEG1);

    repeat (RANDOM_ITEMS) add_random_pair();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_pairs_q.size() != 0 || pts_if.valid) @(posedge clk_i);
    while (expected_dist_q.size() != 0) @(posedge clk_i);
    // let any stray result show up before the verdict
    repeat (2 * PIPE_LAT) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
